@@ design/cpseg_pkg.sv @@
// ----------------------------------------------------------------------------
// cpseg_pkg
// Shared codes for the closest-point-on-segment block: result regions and
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cpseg_pkg;

	// Which case produced a result
	typedef enum logic [1:0] {
		REGION_INTERIOR = 2'd0,
		REGION_START    = 2'd1,
		REGION_END      = 2'd2
	} region_t;

	// Configuration register indexes (byte address is 4 * index)
	typedef enum logic [1:0] {
		REG_START_X = 2'd0,
		REG_START_Y = 2'd1,
		REG_END_X   = 2'd2,
		REG_END_Y   = 2'd3
	} reg_idx_t;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

endpackage

`default_nettype wire

@@ design/cpseg_scale_lane.sv @@
// ----------------------------------------------------------------------------
// cpseg_scale_lane
// Pipelined scaler: q = floor(m * s / d) for 0 < s < d, one bit of m per
// stage, most significant bit first. m and d are static while requests are
// in flight; s travels with its request.
// ----------------------------------------------------------------------------
`default_nettype none

module cpseg_scale_lane #(
	parameter int W = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [W:0]           m,
	input  wire logic [2*W+1:0]       d,
	input  wire logic [2*W+1:0]       s_in,
	output logic      [W:0]           q
);

	localparam int N  = W + 1;
	localparam int DW = 2 * W + 2;
	localparam int TW = DW + 2;

	logic [DW-1:0] r_sc [N];
	logic [DW-1:0] s_sc [N];
	logic [N-1:0]  q_sc [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [DW-1:0] s_cur;
		logic [N-1:0]  q_in;
		logic [TW-1:0] t;
		logic [TW-1:0] d1;
		logic [TW-1:0] d2;
		logic [DW-1:0] r_nxt;
		logic [N-1:0]  q_nxt;

		if (k == 0) begin : g_first
			assign r_in  = '0;
			assign q_in  = '0;
			assign s_cur = s_in;
		end else begin : g_rest
			assign r_in  = r_sc[k-1];
			assign q_in  = q_sc[k-1];
			assign s_cur = s_sc[k-1];
		end

		assign d1 = TW'(d);
		assign d2 = {1'b0, d, 1'b0};

		always_comb begin
			// remainder stays below d, so the partial sum stays below 3d
			t = {1'b0, r_in, 1'b0} + (m[N-1-k] ? TW'(s_cur) : '0);
			if (t >= d2) begin
				r_nxt = DW'(t - d2);
				q_nxt = {q_in[N-2:0], 1'b0} + N'(2);
			end else if (t >= d1) begin
				r_nxt = DW'(t - d1);
				q_nxt = {q_in[N-2:0], 1'b0} + N'(1);
			end else begin
				r_nxt = DW'(t);
				q_nxt = {q_in[N-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_sc[k] <= r_nxt;
				q_sc[k] <= q_nxt;
				s_sc[k] <= s_cur;
			end
		end
	end

	assign q = q_sc[N-1];

endmodule

`default_nettype wire

@@ design/closest_point_on_segment_2d.sv @@
// ----------------------------------------------------------------------------
// closest_point_on_segment_2d
// Throughput: one request per cycle while the skid slot is empty; four front
//   stages, then one scaler stage per bit of |end - start| (COORD_WIDTH + 1),
//   then the output register.
// Reset: arst_n clears all valid bits and the skid slot and loads the segment
//   (0,0) -> (1.0,0); payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_point_on_segment_2d #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// request stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// [W-1:0] px, [2W-1:W] py, zero padded to whole bytes
	input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
	// result stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// [W-1:0] rx, [2W-1:W] ry, [2W+1:2W] region, zero padded to whole bytes
	output logic      [((2*COORD_WIDTH+2+7)/8)*8-1:0]   m_tdata,
	// configuration port
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [cpseg_pkg::APB_AW-1:0]           paddr,
	input  wire logic [cpseg_pkg::APB_DW-1:0]           pwdata,
	output logic      [cpseg_pkg::APB_DW-1:0]           prdata,
	output logic                                        pready
);

	import cpseg_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int N   = W + 1;          // scaler stages, one per bit of |d|
	localparam int PW  = 2 * W + 2;      // product width
	localparam int DW  = 2 * W + 2;      // squared length / dot magnitude
	localparam int SW  = 2 * W + 3;      // signed dot product
	localparam int ODW = ((2 * W + 2 + 7) / 8) * 8;
	localparam logic [W-1:0] END_X_RST = W'(256);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= END_X_RST;
			end_y_q   <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_START_X: start_x_q <= pwdata[W-1:0];
				REG_START_Y: start_y_q <= pwdata[W-1:0];
				REG_END_X:   end_x_q   <= pwdata[W-1:0];
				REG_END_Y:   end_y_q   <= pwdata[W-1:0];
				default:     ;
			endcase
		end
	end

	// Read back sign-extended
	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_START_X: prdata = APB_DW'(start_x_q);
			REG_START_Y: prdata = APB_DW'(start_y_q);
			REG_END_X:   prdata = APB_DW'(end_x_q);
			REG_END_Y:   prdata = APB_DW'(end_y_q);
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Segment terms. Config must change only while idle; the block does not
	// enforce it. So these settle before any request needs them: direction,
	// its magnitude and sign, and squared length (multiply, then add, each registered).
	// ------------------------------------------------------------------
	logic signed [W:0]    dx_q, dy_q;
	logic        [W:0]    dxm_q, dym_q;
	logic                 dxn_q, dyn_q;
	logic        [DW-1:0] dsqx_q, dsqy_q, l2_q;

	always_ff @(posedge clk) begin
		dx_q   <= (W+1)'(end_x_q) - (W+1)'(start_x_q);
		dy_q   <= (W+1)'(end_y_q) - (W+1)'(start_y_q);
		dxn_q  <= dx_q[W];
		dyn_q  <= dy_q[W];
		dxm_q  <= dx_q[W] ? (W+1)'(-dx_q) : (W+1)'(dx_q);
		dym_q  <= dy_q[W] ? (W+1)'(-dy_q) : (W+1)'(dy_q);
		dsqx_q <= DW'(PW'(dx_q) * PW'(dx_q));
		dsqy_q <= DW'(PW'(dy_q) * PW'(dy_q));
		l2_q   <= dsqx_q + dsqy_q;
	end

	// ------------------------------------------------------------------
	// Pipeline control: everything advances together unless the skid slot
	// is holding a result, so a stall freezes the pipe and drops nothing.
	// ------------------------------------------------------------------
	logic en;
	logic sk_vld_q;

	assign en       = !sk_vld_q;
	assign s_tready = en;

	// Stage 1: offset of the point from the start
	logic                 v_s1;
	logic signed [W:0]    ex_s1, ey_s1;

	// Stage 2: the two dot-product terms
	logic                 v_s2;
	logic signed [PW-1:0] pxx_s2, pyy_s2;

	// Stage 3: dot product
	logic                 v_s3;
	logic signed [SW-1:0] s_s3;

	// Stage 4: classify, hand the dot magnitude to the scalers
	logic                 v_s4;
	region_t              region_s4;
	logic        [DW-1:0] s_s4;

	logic signed [SW-1:0] l2_ext;
	region_t              region_c;

	assign l2_ext = SW'({1'b0, l2_q});

	always_comb begin
		if (l2_q == '0) begin
			region_c = REGION_START;      // degenerate segment
		end else if (s_s3 >= l2_ext) begin
			region_c = REGION_END;
		end else if (s_s3 <= 0) begin
			region_c = REGION_START;
		end else begin
			region_c = REGION_INTERIOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1     <= (W+1)'($signed(s_tdata[W-1:0]))   - (W+1)'(start_x_q);
			ey_s1     <= (W+1)'($signed(s_tdata[2*W-1:W])) - (W+1)'(start_y_q);
			pxx_s2    <= PW'(ex_s1) * PW'(dx_q);
			pyy_s2    <= PW'(ey_s1) * PW'(dy_q);
			s_s3      <= SW'(pxx_s2) + SW'(pyy_s2);
			region_s4 <= region_c;
			s_s4      <= DW'(s_s3);
		end
	end

	// ------------------------------------------------------------------
	// Scaler stages: one lane per coordinate, region travels alongside
	// ------------------------------------------------------------------
	logic        vld_sc    [N];
	region_t     region_sc [N];
	logic [W:0]  qx, qy;

	cpseg_scale_lane #(.W(W)) u_lane_x (
		.clk  (clk),
		.en   (en),
		.m    (dxm_q),
		.d    (l2_q),
		.s_in (s_s4),
		.q    (qx)
	);

	cpseg_scale_lane #(.W(W)) u_lane_y (
		.clk  (clk),
		.en   (en),
		.m    (dym_q),
		.d    (l2_q),
		.s_in (s_s4),
		.q    (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				vld_sc[k] <= 1'b0;
			end
		end else if (en) begin
			vld_sc[0] <= v_s4;
			for (int k = 1; k < N; k++) begin
				vld_sc[k] <= vld_sc[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			region_sc[0] <= region_s4;
			for (int k = 1; k < N; k++) begin
				region_sc[k] <= region_sc[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stage: step from the start point by the scaled offset, or
	// take an end point outright
	// ------------------------------------------------------------------
	logic [W:0]   mvx, mvy;
	logic [W-1:0] rx_c, ry_c;

	assign mvx = dxn_q ? (W+1)'(start_x_q) - qx : (W+1)'(start_x_q) + qx;
	assign mvy = dyn_q ? (W+1)'(start_y_q) - qy : (W+1)'(start_y_q) + qy;

	always_comb begin
		case (region_sc[N-1])
			REGION_END: begin
				rx_c = end_x_q;
				ry_c = end_y_q;
			end
			REGION_INTERIOR: begin
				rx_c = mvx[W-1:0];
				ry_c = mvy[W-1:0];
			end
			default: begin
				rx_c = start_x_q;
				ry_c = start_y_q;
			end
		endcase
	end

	logic         out_vld_q;
	logic [W-1:0] out_rx_q, out_ry_q;
	region_t      out_region_q;
	logic [W-1:0] sk_rx_q, sk_ry_q;
	region_t      sk_region_q;

	// Output register plus one skid slot: when the consumer stalls, park the
	// waiting result in the skid slot and keep taking one more request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_sc[N-1];
			sk_vld_q  <= out_vld_q && !m_tready;
		end else if (m_tready) begin
			sk_vld_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rx_q     <= rx_c;
			out_ry_q     <= ry_c;
			out_region_q <= region_sc[N-1];
			sk_rx_q      <= out_rx_q;
			sk_ry_q      <= out_ry_q;
			sk_region_q  <= out_region_q;
		end
	end

	// The skid slot always holds the older result
	assign m_tvalid = sk_vld_q || out_vld_q;
	assign m_tdata  = sk_vld_q ?
		ODW'({sk_region_q, sk_ry_q, sk_rx_q}) :
		ODW'({out_region_q, out_ry_q, out_rx_q});

`ifndef SYNTHESIS
	// Interior results only come from a segment of nonzero length
	a_interior_nondegenerate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_region_q == REGION_INTERIOR) |-> (l2_q != '0))
		else $error("interior result on a degenerate segment");

	// Scaled offset never reaches the full direction component
	a_scale_below_x: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sc[N-1] && region_sc[N-1] == REGION_INTERIOR) |->
		((qx < dxm_q) || (qx == '0)))
		else $error("x scaler quotient out of range");

	a_scale_below_y: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sc[N-1] && region_sc[N-1] == REGION_INTERIOR) |->
		((qy < dym_q) || (qy == '0)))
		else $error("y scaler quotient out of range");

	// The skid slot fills only from a stalled, valid output register
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_vld_q) |-> $past(out_vld_q && !m_tready))
		else $error("skid slot filled without a stalled result");
`endif

endmodule

`default_nettype wire

@@ dv/closest_point_on_segment_2d_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// closest_point_on_segment_2d_tb
// Streams query points through the block and checks every closest point and
// region code against a predictor kept inside this bench. Segments are loaded
// over the register port between bursts, and each register is read back. Both
// stream sides stall at random; one burst runs with no stalls at all.
// ----------------------------------------------------------------------------

module closest_point_on_segment_2d_tb;

	import cpseg_pkg::*;

	// Give up after this many cycles with no handshake on any port
	localparam int STALL_LIMIT = 2000;

	// Request as it sits on s_tdata: px in the low half, py in the high half
	typedef struct packed {
		logic [15:0] py;
		logic [15:0] px;
	} point_t;

	typedef struct packed {
		logic [15:0] rx;
		logic [15:0] ry;
		region_t     region;
	} closest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [15:0] px, [31:16] py
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [15:0] rx, [31:16] ry, [33:32] region, [39:34] zero
	logic [39:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Segment as the block should hold it; starts at the reset values
	logic signed [15:0] seg_ax = 16'sd0;
	logic signed [15:0] seg_ay = 16'sd0;
	logic signed [15:0] seg_bx = 16'sd256;
	logic signed [15:0] seg_by = 16'sd0;

	point_t   point_q[$];    // points waiting to be presented
	closest_t closest_q[$];  // closest points still owed by the block

	int mismatches = 0;
	int quiet_cycles = 0;
	int idle_pct = 27;
	bit req_taken = 1'b0;    // a request was accepted at the last rising edge

	closest_point_on_segment_2d DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// Project the point onto the current segment. Every product fits in 64 bits
	// at this width, so form s and |d|^2 exactly; signed division truncates
	// toward zero, which is what the interior case needs.
	function automatic closest_t closest_point(input logic signed [15:0] px,
			input logic signed [15:0] py);
		longint dx, dy, ex, ey, dot, len2;
		closest_t r;
		dx = longint'(seg_bx) - longint'(seg_ax);
		dy = longint'(seg_by) - longint'(seg_ay);
		ex = longint'(px) - longint'(seg_ax);
		ey = longint'(py) - longint'(seg_ay);
		dot = ex * dx + ey * dy;
		len2 = dx * dx + dy * dy;
		if (len2 == 0) begin
			// degenerate segment: fall back to the start point
			r.rx = seg_ax;
			r.ry = seg_ay;
			r.region = REGION_START;
		end else if (dot >= len2) begin
			r.rx = seg_bx;
			r.ry = seg_by;
			r.region = REGION_END;
		end else if (dot <= 0) begin
			r.rx = seg_ax;
			r.ry = seg_ay;
			r.region = REGION_START;
		end else begin
			r.rx = 16'(longint'(seg_ax) + dx * dot / len2);
			r.ry = 16'(longint'(seg_ay) + dy * dot / len2);
			r.region = REGION_INTERIOR;
		end
		return r;
	endfunction

	// Request driver: hold a request until it is taken, then present the next
	// pending point unless this cycle idles. Assign each output once per edge.
	always @(negedge clk) begin : drive_requests
		logic   nxt_valid;
		point_t nxt_point;
		nxt_valid = s_tvalid;
		nxt_point = s_tdata;
		if (!arst_n) begin
			nxt_valid = 1'b0;
		end else if (!s_tvalid || req_taken) begin
			nxt_valid = 1'b0;
			if (point_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt_point = point_q.pop_front();
				nxt_valid = 1'b1;
			end
		end
		s_tvalid <= nxt_valid;
		s_tdata <= nxt_point;
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	// Monitor: predict on each accepted request, check each accepted result,
	// and watch for a hung pipeline.
	always @(posedge clk) begin : watch_streams
		closest_t want;
		req_taken = s_tvalid && s_tready;
		if (req_taken)
			closest_q.push_back(closest_point(s_tdata[15:0], s_tdata[31:16]));
		if (m_tvalid && m_tready) begin
			if (closest_q.size() == 0) begin
				report_mismatch($sformatf("result %h with no request pending", m_tdata));
			end else begin
				want = closest_q.pop_front();
				if (m_tdata[15:0] !== want.rx)
					report_mismatch($sformatf("rx %h, want %h", m_tdata[15:0], want.rx));
				if (m_tdata[31:16] !== want.ry)
					report_mismatch($sformatf("ry %h, want %h", m_tdata[31:16], want.ry));
				if (m_tdata[33:32] !== want.region)
					report_mismatch($sformatf("region %0d, want %s", m_tdata[33:32],
						want.region.name()));
			end
		end
		if (req_taken || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Write one register (setup, then access), then read it back the same way.
	task automatic write_reg(input reg_idx_t idx, input logic signed [15:0] value);
		logic [31:0] readback;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{16{value[15]}}, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		// write landed at the last rising edge; follow with a read
		case (idx)
			REG_START_X: seg_ax = value;
			REG_START_Y: seg_ay = value;
			REG_END_X:   seg_bx = value;
			REG_END_Y:   seg_by = value;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback[15:0] !== value)
			report_mismatch($sformatf("register %s reads %h, wrote %h", idx.name(),
				readback[15:0], value));
	endtask

	task automatic set_segment(input logic signed [15:0] ax, ay, bx, by);
		write_reg(REG_START_X, ax);
		write_reg(REG_START_Y, ay);
		write_reg(REG_END_X, bx);
		write_reg(REG_END_Y, by);
	endtask

	task automatic add_point(input logic signed [15:0] x, y);
		point_q.push_back({y, x});
	endtask

	// Wait until every request is presented and every result is back, then
	// let the pipeline settle before touching registers again.
	task automatic drain(input int settle);
		while (point_q.size() != 0 || s_tvalid || closest_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return 16'(v);
	endfunction

	initial begin : stimulus
		logic signed [15:0] ax, ay, bx, by;
		longint nx, ny;
		int t;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset segment (0,0) -> (1.0,0): both clamps, the boundaries, interior
		add_point(0, 0);
		add_point(256, 0);
		add_point(1, 0);
		add_point(255, -32768);
		add_point(128, 32767);
		add_point(-1, 5);
		add_point(257, 0);
		add_point(-32768, -32768);
		add_point(32767, 32767);
		drain(4);

		// Longest possible segment, pointing down-left, so the deltas are
		// negative and the scaled offset truncates toward the start point
		set_segment(32767, 32767, -32768, -32768);
		add_point(0, 0);
		add_point(-32768, 32767);
		add_point(32767, -32768);
		add_point(-32768, -32768);
		add_point(32767, 32767);
		add_point(100, -101);
		drain(4);

		// Degenerate segment: start equals end
		set_segment(-5, 7, -5, 7);
		add_point(-5, 7);
		add_point(32767, -32768);
		add_point(0, 0);
		drain(4);

		// Short segment with mixed-sign deltas
		set_segment(10, 20, 7, 25);
		add_point(8, 22);
		add_point(9, 21);
		add_point(11, 19);
		drain(4);

		// Random bursts over several kinds of segment
		for (int burst = 0; burst < 8; burst++) begin
			ax = rand_coord();
			ay = rand_coord();
			bx = rand_coord();
			by = rand_coord();
			case (burst % 8)
				1: begin
					// short: a few LSBs long
					ax = 16'($urandom_range(60000)) - 16'sd30000;
					ay = 16'($urandom_range(60000)) - 16'sd30000;
					bx = ax + 16'($urandom_range(16)) - 16'sd8;
					by = ay + 16'($urandom_range(16)) - 16'sd8;
				end
				2: by = ay;
				3: begin
					ax = -32768;
					ay = 32767;
					bx = 32767;
					by = -32768;
				end
				4: begin
					bx = ax;
					by = ay;
				end
				5: bx = ax;
				default: ;
			endcase
			set_segment(ax, ay, bx, by);
			// one burst with no stalls on either side
			idle_pct = (burst == 6) ? 0 : 27;
			for (int n = 0; n < 160; n++) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4: add_point(rand_coord(), rand_coord());
					5: add_point(seg_ax, seg_ay);
					6: add_point(seg_bx, seg_by);
					default: begin
						// near the segment, sometimes a little past either end
						t = int'($urandom_range(1152)) - 64;
						nx = longint'(seg_ax) + (longint'(seg_bx) - longint'(seg_ax)) * t / 1024
							+ longint'($urandom_range(128)) - 64;
						ny = longint'(seg_ay) + (longint'(seg_by) - longint'(seg_ay)) * t / 1024
							+ longint'($urandom_range(128)) - 64;
						add_point(clamp16(nx), clamp16(ny));
					end
				endcase
			end
			drain(4);
		end
		idle_pct = 27;

		drain(40);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
